[hdl/psp_pkg.sv]
// ----------------------------------------------------------------------------
// Procedural solid pattern package
// Shared widths, codes and word layouts for the pattern block.
// ----------------------------------------------------------------------------
package psp_pkg;

  localparam int FRAC_BITS_DEF    = 16;
  localparam int CHANNEL_BITS_DEF = 8;
  localparam int COORD_BITS       = 32;
  localparam int OUT_BITS         = 8;
  localparam int MODE_BITS        = 3;
  localparam int CFG_INDEX_BITS   = 2;
  localparam int ROOT_BITS        = 32;
  localparam int SQ_BITS          = 2 * ROOT_BITS;
  localparam int QUEUE_DEPTH      = 4;
  localparam int OUT_DEPTH        = 2;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_CHECKER  = 3'd0,
    MODE_STRIPE   = 3'd1,
    MODE_RING     = 3'd2,
    MODE_GRADIENT = 3'd3,
    MODE_RADIAL   = 3'd4
  } mode_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_MODE    = 2'd0,
    CFG_COLOR_A = 2'd1,
    CFG_COLOR_B = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    KIND_FLAT   = 2'd0,
    KIND_RING   = 2'd1,
    KIND_GRAD   = 2'd2,
    KIND_RADIAL = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic                  use_b;
    logic [COORD_BITS-1:0] abs_x;
    logic [COORD_BITS-1:0] abs_z;
    logic [COORD_BITS-1:0] x;
  } front_word_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] red;
    logic [OUT_BITS-1:0] green;
    logic [OUT_BITS-1:0] blue;
  } pixel_t;

endpackage

[hdl/procedural_solid_pattern_top.sv]
// ----------------------------------------------------------------------------
// Procedural solid pattern
// Maps a pattern-space point to a checker, stripe, ring, gradient or radial
// gradient color.
//
// Points enter as a word on push/full and are taken at an edge where push is
// high and full is low. Colors leave as a word on empty/pop: the oldest color
// is on red, green and blue while empty is low and is taken when pop is high.
// The cfg_valid/cfg_ready channel writes pattern_mode, color_a and color_b by
// index; cfg_ready is always high. The user must make writes only while no
// point is in flight; the block itself does not enforce this.
// One point is accepted every cycle while full is low. Each point passes the
// front register, the work queue, the squaring and summing stages, the
// 32-stage square root pipeline and the blend stage into the output queue.
// When pop stays low the output queue fills, the back end holds, the work
// queue fills and full rises; no word is dropped.
// Reset empties all queues and pipelines, selects the checker pattern, sets
// color A to white and color B to black.
// ----------------------------------------------------------------------------
module procedural_solid_pattern_top #(
  parameter int FRAC_BITS    = psp_pkg::FRAC_BITS_DEF,
  parameter int CHANNEL_BITS = psp_pkg::CHANNEL_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [psp_pkg::COORD_BITS-1:0] point_x,
  input  logic signed [psp_pkg::COORD_BITS-1:0] point_y,
  input  logic signed [psp_pkg::COORD_BITS-1:0] point_z,
  output logic                                  empty,
  input  logic                                  pop,
  output logic [psp_pkg::OUT_BITS-1:0]          red,
  output logic [psp_pkg::OUT_BITS-1:0]          green,
  output logic [psp_pkg::OUT_BITS-1:0]          blue,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [psp_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [3*CHANNEL_BITS-1:0]             cfg_data
);

  import psp_pkg::*;

  localparam int COLOR_BITS = 3 * CHANNEL_BITS;

  logic [MODE_BITS-1:0]  pattern_mode;
  logic [COLOR_BITS-1:0] color_a;
  logic [COLOR_BITS-1:0] color_b;

  logic        fq_push;
  logic        fq_full;
  front_word_t fq_wdata;
  logic        fq_pop;
  front_word_t fq_rdata;
  logic        fq_empty;

  logic        oq_push;
  logic        oq_full;
  pixel_t      oq_wdata;
  pixel_t      oq_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_mode <= MODE_CHECKER;
      color_a      <= '1;
      color_b      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_t'(cfg_index))
        CFG_MODE: begin
          pattern_mode <= cfg_data[MODE_BITS-1:0];
        end
        CFG_COLOR_A: begin
          color_a <= cfg_data;
        end
        CFG_COLOR_B: begin
          color_b <= cfg_data;
        end
        default: begin
          color_b <= color_b;
        end
      endcase
    end
  end

  psp_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .point_x      (point_x),
    .point_y      (point_y),
    .point_z      (point_z),
    .pattern_mode (pattern_mode),
    .q_push       (fq_push),
    .q_full       (fq_full),
    .q_word       (fq_wdata)
  );

  psp_fifo #(
    .WIDTH ($bits(front_word_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_work_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (fq_push),
    .wdata (fq_wdata),
    .full  (fq_full),
    .pop   (fq_pop),
    .rdata (fq_rdata),
    .empty (fq_empty)
  );

  psp_back #(
    .FRAC_BITS    (FRAC_BITS),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (fq_empty),
    .q_pop   (fq_pop),
    .q_word  (fq_rdata),
    .color_a (color_a),
    .color_b (color_b),
    .o_full  (oq_full),
    .o_push  (oq_push),
    .o_word  (oq_wdata)
  );

  psp_fifo #(
    .WIDTH ($bits(pixel_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (oq_push),
    .wdata (oq_wdata),
    .full  (oq_full),
    .pop   (pop),
    .rdata (oq_rdata),
    .empty (empty)
  );

  assign red   = oq_rdata.red;
  assign green = oq_rdata.green;
  assign blue  = oq_rdata.blue;

endmodule

[hdl/psp_fifo.sv]
// ----------------------------------------------------------------------------
// Pattern word queue
// Small first-in first-out buffer of registers with push/full and pop/empty.
// ----------------------------------------------------------------------------
module psp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign full    = (count == CNT_BITS'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

[hdl/psp_front.sv]
// ----------------------------------------------------------------------------
// Pattern front end
// Accepts points, classifies them by pattern mode and forms the parity and
// the coordinate magnitudes before handing a word to the work queue.
// ----------------------------------------------------------------------------
module psp_front #(
  parameter int FRAC_BITS = psp_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [psp_pkg::COORD_BITS-1:0] point_x,
  input  logic signed [psp_pkg::COORD_BITS-1:0] point_y,
  input  logic signed [psp_pkg::COORD_BITS-1:0] point_z,
  input  logic [psp_pkg::MODE_BITS-1:0]         pattern_mode,
  output logic                                 q_push,
  input  logic                                 q_full,
  output psp_pkg::front_word_t                 q_word
);

  import psp_pkg::*;

  logic        valid;
  front_word_t word;
  front_word_t word_next;
  logic        load;

  assign full   = valid && q_full;
  assign q_push = valid && !q_full;
  assign load   = push && !full;
  assign q_word = word;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (q_push) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word <= word_next;
    end
  end

  always_comb begin
    word_next.kind  = KIND_FLAT;
    word_next.use_b = 1'b0;
    word_next.abs_x = point_x[COORD_BITS-1] ? COORD_BITS'(-point_x) : COORD_BITS'(point_x);
    word_next.abs_z = point_z[COORD_BITS-1] ? COORD_BITS'(-point_z) : COORD_BITS'(point_z);
    word_next.x     = COORD_BITS'(point_x);
    case (mode_t'(pattern_mode))
      MODE_CHECKER: begin
        word_next.use_b = point_x[FRAC_BITS] ^ point_y[FRAC_BITS] ^ point_z[FRAC_BITS];
      end
      MODE_STRIPE: begin
        word_next.use_b = point_x[FRAC_BITS];
      end
      MODE_RING: begin
        word_next.kind = KIND_RING;
      end
      MODE_GRADIENT: begin
        word_next.kind = KIND_GRAD;
      end
      MODE_RADIAL: begin
        word_next.kind = KIND_RADIAL;
      end
      default: begin
        word_next.kind = KIND_FLAT;
      end
    endcase
  end

endmodule

[hdl/psp_back.sv]
// ----------------------------------------------------------------------------
// Pattern back end
// Squares and sums the magnitudes, takes the integer square root one bit per
// stage, then selects or blends the two colors into a pixel word.
// ----------------------------------------------------------------------------
module psp_back #(
  parameter int FRAC_BITS    = psp_pkg::FRAC_BITS_DEF,
  parameter int CHANNEL_BITS = psp_pkg::CHANNEL_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  output logic                        q_pop,
  input  psp_pkg::front_word_t        q_word,
  input  logic [3*CHANNEL_BITS-1:0]   color_a,
  input  logic [3*CHANNEL_BITS-1:0]   color_b,
  input  logic                        o_full,
  output logic                        o_push,
  output psp_pkg::pixel_t             o_word
);

  import psp_pkg::*;

  localparam int CW = CHANNEL_BITS;
  localparam int PW = CW + FRAC_BITS + 2;

  logic adv;

  logic                  v0;
  kind_t                 kind0;
  logic                  ub0;
  logic [FRAC_BITS-1:0]  frac0;
  logic [SQ_BITS-1:0]    sqx;
  logic [SQ_BITS-1:0]    sqz;

  logic                  vr    [ROOT_BITS+1];
  kind_t                 kindr [ROOT_BITS+1];
  logic                  ubr   [ROOT_BITS+1];
  logic [FRAC_BITS-1:0]  fracr [ROOT_BITS+1];
  logic [SQ_BITS-1:0]    rem   [ROOT_BITS+1];
  logic [ROOT_BITS-1:0]  root  [ROOT_BITS+1];

  logic                  mv;
  logic                  m_blend;
  logic                  m_use_b;
  logic signed [PW-1:0]  m_prod [3];

  logic [FRAC_BITS-1:0]  frac_sel;
  logic                  use_b_sel;
  logic                  blend_sel;
  logic [CW-1:0]         ch_a [3];
  logic [CW-1:0]         ch_b [3];
  logic signed [PW-1:0]  prod_next [3];
  logic [CW-1:0]         ch_out [3];

  assign adv    = !(mv && o_full);
  assign q_pop  = adv && !q_empty;
  assign o_push = mv && !o_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0    <= 1'b0;
      vr[0] <= 1'b0;
      mv    <= 1'b0;
    end else if (adv) begin
      v0    <= q_pop;
      vr[0] <= v0;
      mv    <= vr[ROOT_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind0    <= q_word.kind;
      ub0      <= q_word.use_b;
      frac0    <= q_word.x[FRAC_BITS-1:0];
      sqx      <= SQ_BITS'(q_word.abs_x) * SQ_BITS'(q_word.abs_x);
      sqz      <= SQ_BITS'(q_word.abs_z) * SQ_BITS'(q_word.abs_z);
      kindr[0] <= kind0;
      ubr[0]   <= ub0;
      fracr[0] <= frac0;
      rem[0]   <= sqx + sqz;
      root[0]  <= '0;
    end
  end

  for (genvar s = 0; s < ROOT_BITS; s++) begin : g_root
    localparam int BIT = ROOT_BITS - 1 - s;
    logic [SQ_BITS-1:0] trial;
    logic               ge;

    assign trial = (SQ_BITS'(root[s]) << (2 * BIT + 2)) | (SQ_BITS'(1) << (2 * BIT));
    assign ge    = (rem[s] >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vr[s+1] <= 1'b0;
      end else if (adv) begin
        vr[s+1] <= vr[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        kindr[s+1] <= kindr[s];
        ubr[s+1]   <= ubr[s];
        fracr[s+1] <= fracr[s];
        rem[s+1]   <= ge ? rem[s] - trial : rem[s];
        root[s+1]  <= {root[s][ROOT_BITS-2:0], ge};
      end
    end
  end

  always_comb begin
    frac_sel  = root[ROOT_BITS][FRAC_BITS-1:0];
    use_b_sel = ubr[ROOT_BITS];
    blend_sel = 1'b0;
    case (kindr[ROOT_BITS])
      KIND_RING: begin
        use_b_sel = root[ROOT_BITS][FRAC_BITS];
      end
      KIND_GRAD: begin
        blend_sel = 1'b1;
        frac_sel  = fracr[ROOT_BITS];
      end
      KIND_RADIAL: begin
        blend_sel = 1'b1;
      end
      default: begin
        blend_sel = 1'b0;
      end
    endcase
    for (int c = 0; c < 3; c++) begin
      ch_a[c]      = color_a[(2 - c) * CW +: CW];
      ch_b[c]      = color_b[(2 - c) * CW +: CW];
      prod_next[c] = PW'((signed'({1'b0, ch_b[c]}) - signed'({1'b0, ch_a[c]}))
                     * signed'({1'b0, frac_sel}));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_blend <= blend_sel;
      m_use_b <= use_b_sel;
      for (int c = 0; c < 3; c++) begin
        m_prod[c] <= prod_next[c];
      end
    end
  end

  always_comb begin
    logic signed [PW-1:0] acc;
    acc = '0;
    for (int c = 0; c < 3; c++) begin
      acc = signed'(PW'({ch_a[c], {FRAC_BITS{1'b0}}})) + m_prod[c];
      if (m_blend) begin
        ch_out[c] = acc[FRAC_BITS +: CW];
      end else if (m_use_b) begin
        ch_out[c] = ch_b[c];
      end else begin
        ch_out[c] = ch_a[c];
      end
    end
    o_word.red   = OUT_BITS'(ch_out[0]);
    o_word.green = OUT_BITS'(ch_out[1]);
    o_word.blue  = OUT_BITS'(ch_out[2]);
  end

endmodule
